[design/hcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hcd_pkg;
    localparam logic [7:0] OP_CALIBRATE   = 8'hCA;
    localparam logic [7:0] OP_ANGLE       = 8'hCB;
    localparam logic [7:0] OP_START       = 8'hCC;
    localparam logic [7:0] OP_STOP        = 8'hCD;
    localparam logic [7:0] OP_RESET       = 8'hCE;
    localparam logic [7:0] OP_CALIB_DATA  = 8'hCF;
    localparam logic [7:0] OP_MOTOR       = 8'hD0;
    localparam logic [7:0] OP_STREAM_MODE = 8'hD1;
    localparam logic [7:0] LEGACY_CAL     = 8'h63;
    localparam logic [7:0] LEGACY_CLEAR   = 8'h62;

    typedef enum logic [1:0] {
        PEND_ANGLE  = 2'd0,
        PEND_CALIB  = 2'd1,
        PEND_MOTOR  = 2'd2,
        PEND_STREAM = 2'd3
    } pend_t;

    typedef enum logic [3:0] {
        KIND_CALIBRATE = 4'd0,
        KIND_START     = 4'd1,
        KIND_STOP      = 4'd2,
        KIND_RESET     = 4'd3,
        KIND_CLEAR     = 4'd4,
        KIND_ANGLE     = 4'd5,
        KIND_CALIB     = 4'd6,
        KIND_MOTOR     = 4'd7,
        KIND_MODE_ACK  = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  elem_index;
        logic [31:0] word;
        logic        ack_status;
        logic        last;
        logic        control_on;
        logic        drive_mode;
        logic        stream_format;
    } cmd_t;

    function automatic logic [31:0] round_float(input logic [31:0] bits);
        logic [7:0]  e;
        logic [23:0] mant;
        logic [31:0] mag;
        logic [4:0]  s;
        logic [32:0] sum;
        e = bits[30:23];
        mant = {1'b1, bits[22:0]};
        mag = '0;
        s = '0;
        sum = '0;
        if (e == 8'hFF || e < 8'd126) begin
            round_float = '0;
        end else if (e >= 8'd158) begin
            round_float = bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            if (e >= 8'd150) begin
                mag = {8'd0, mant} << (e - 8'd150);
            end else begin
                s = 5'(8'd150 - e);
                sum = {9'd0, mant} + (33'd1 << (s - 5'd1));
                mag = 32'(sum >> s);
            end
            round_float = bits[31] ? (32'd0 - mag) : mag;
        end
    endfunction
endpackage
`default_nettype wire

[design/hcd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module hcd_front #(
    parameter int NUM_JOINTS = 16,
    parameter int NUM_SERVOS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    output logic              cmd_valid,
    input  wire logic         cmd_ready,
    output hcd_pkg::cmd_t     cmd
);
    logic            collecting_reg, collecting_next;
    hcd_pkg::pend_t  pending_reg, pending_next;
    logic [1:0]      byte_count_reg, byte_count_next;
    logic [6:0]      elem_count_reg, elem_count_next;
    logic [31:0]     word_reg, word_next;
    logic            enable_reg, enable_next;
    logic            mode_reg, mode_next;
    logic            stream_reg, stream_next;
    logic            cmd_valid_reg, cmd_valid_next;
    hcd_pkg::cmd_t   cmd_reg, cmd_next;
    logic            emit;
    logic [31:0]     word_full;
    logic [15:0]     half;
    logic            last_joint, last_servo;

    assign in_ready  = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;
    assign word_full = word_reg | ({24'd0, in_byte} << {byte_count_reg, 3'b000});
    assign half      = {word_reg[7:0], in_byte};
    assign last_joint = (elem_count_reg + 7'd1) >= 7'(NUM_JOINTS);
    assign last_servo = (elem_count_reg + 7'd1) >= 7'(NUM_SERVOS);

    always_comb begin
        collecting_next = collecting_reg;
        pending_next    = pending_reg;
        byte_count_next = byte_count_reg;
        elem_count_next = elem_count_reg;
        word_next       = word_reg;
        enable_next     = enable_reg;
        mode_next       = mode_reg;
        stream_next     = stream_reg;
        emit            = 1'b0;
        cmd_next        = cmd_reg;
        cmd_next.kind       = hcd_pkg::KIND_CALIBRATE;
        cmd_next.elem_index = '0;
        cmd_next.word       = '0;
        cmd_next.ack_status = 1'b0;
        cmd_next.last       = 1'b0;
        if (collecting_reg) begin
            cmd_next.elem_index = elem_count_reg[5:0];
            case (pending_reg)
                hcd_pkg::PEND_STREAM: begin
                    emit = 1'b1;
                    collecting_next = 1'b0;
                    if (in_byte <= 8'd1) begin
                        stream_next = in_byte[0];
                    end else begin
                        cmd_next.ack_status = 1'b1;
                    end
                    cmd_next.kind = hcd_pkg::KIND_MODE_ACK;
                    cmd_next.elem_index = '0;
                    cmd_next.word = {31'd0, stream_next};
                end
                hcd_pkg::PEND_MOTOR: begin
                    if (byte_count_reg == 2'd0) begin
                        word_next = {24'd0, in_byte};
                        byte_count_next = 2'd1;
                    end else begin
                        emit = 1'b1;
                        word_next = '0;
                        byte_count_next = '0;
                        elem_count_next = elem_count_reg + 7'd1;
                        cmd_next.kind = hcd_pkg::KIND_MOTOR;
                        cmd_next.word = {{16{half[15]}}, half};
                        cmd_next.last = last_servo;
                        if (last_servo) begin
                            mode_next = 1'b1;
                            collecting_next = 1'b0;
                        end
                    end
                end
                default: begin
                    if (byte_count_reg != 2'd3) begin
                        word_next = word_full;
                        byte_count_next = byte_count_reg + 2'd1;
                    end else begin
                        emit = 1'b1;
                        word_next = '0;
                        byte_count_next = '0;
                        elem_count_next = elem_count_reg + 7'd1;
                        cmd_next.last = last_joint;
                        cmd_next.word = word_full;
                        if (pending_reg == hcd_pkg::PEND_ANGLE) begin
                            cmd_next.kind = hcd_pkg::KIND_ANGLE;
                            if (last_joint) begin
                                mode_next = 1'b0;
                            end
                        end else begin
                            cmd_next.kind = hcd_pkg::KIND_CALIB;
                        end
                        if (last_joint) begin
                            collecting_next = 1'b0;
                        end
                    end
                end
            endcase
        end else begin
            case (in_byte)
                hcd_pkg::LEGACY_CAL, hcd_pkg::OP_CALIBRATE: begin
                    emit = 1'b1;
                end
                hcd_pkg::LEGACY_CLEAR: begin
                    emit = 1'b1;
                    cmd_next.kind = hcd_pkg::KIND_CLEAR;
                end
                hcd_pkg::OP_START: begin
                    emit = 1'b1;
                    enable_next = 1'b1;
                    cmd_next.kind = hcd_pkg::KIND_START;
                end
                hcd_pkg::OP_STOP: begin
                    emit = 1'b1;
                    enable_next = 1'b0;
                    cmd_next.kind = hcd_pkg::KIND_STOP;
                end
                hcd_pkg::OP_RESET: begin
                    emit = 1'b1;
                    enable_next = 1'b0;
                    mode_next = 1'b0;
                    cmd_next.kind = hcd_pkg::KIND_RESET;
                end
                hcd_pkg::OP_ANGLE, hcd_pkg::OP_CALIB_DATA,
                hcd_pkg::OP_MOTOR, hcd_pkg::OP_STREAM_MODE: begin
                    collecting_next = 1'b1;
                    pending_next = (in_byte == hcd_pkg::OP_ANGLE)      ? hcd_pkg::PEND_ANGLE :
                                   (in_byte == hcd_pkg::OP_CALIB_DATA) ? hcd_pkg::PEND_CALIB :
                                   (in_byte == hcd_pkg::OP_MOTOR)      ? hcd_pkg::PEND_MOTOR :
                                                                         hcd_pkg::PEND_STREAM;
                    byte_count_next = '0;
                    elem_count_next = '0;
                    word_next = '0;
                end
                default: begin
                end
            endcase
        end
        cmd_next.control_on    = enable_next;
        cmd_next.drive_mode    = mode_next;
        cmd_next.stream_format = stream_next;
        cmd_valid_next = (cmd_valid_reg && !cmd_ready) || emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            pending_reg    <= hcd_pkg::PEND_ANGLE;
            byte_count_reg <= '0;
            elem_count_reg <= '0;
            word_reg       <= '0;
            enable_reg     <= 1'b0;
            mode_reg       <= 1'b0;
            stream_reg     <= 1'b1;
            cmd_valid_reg  <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                collecting_reg <= collecting_next;
                pending_reg    <= pending_next;
                byte_count_reg <= byte_count_next;
                elem_count_reg <= elem_count_next;
                word_reg       <= word_next;
                enable_reg     <= enable_next;
                mode_reg       <= mode_next;
                stream_reg     <= stream_next;
                cmd_valid_reg  <= cmd_valid_next;
            end else if (cmd_ready) begin
                cmd_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready && emit) begin
            cmd_reg <= cmd_next;
        end
    end
endmodule
`default_nettype wire

[design/hcd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module hcd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire hcd_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output hcd_pkg::cmd_t      out_cmd
);
    hcd_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule
`default_nettype wire

[design/hcd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module hcd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire hcd_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output hcd_pkg::cmd_t      out_cmd
);
    logic          valid_reg;
    hcd_pkg::cmd_t cmd_reg, cmd_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

    always_comb begin
        cmd_next = in_cmd;
        if (in_cmd.kind == hcd_pkg::KIND_CALIB) begin
            cmd_next.word = hcd_pkg::round_float(in_cmd.word);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cmd_reg <= cmd_next;
        end
    end
endmodule
`default_nettype wire

[design/host_command_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Host command deframer: takes one host byte per transfer and accepts a byte in every cycle
// while the result side keeps up. A front stage decodes opcodes and assembles frame
// elements into a registered command, a two-entry queue follows, and a back stage rounds
// calibration words to int32 and holds the result register, so a completed element passes
// through the front register, the queue and the back register before it is valid. Bytes that
// start a frame or lie inside an element give no result, nor do unknown opcode bytes.
module host_command_deframer #(
    parameter int NUM_JOINTS = 16,
    parameter int NUM_SERVOS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_rx_byte,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [3:0]        m_kind,
    output logic [5:0]        m_elem_index,
    output logic [31:0]       m_value,
    output logic              m_ack_status,
    output logic              m_last,
    output logic              m_control_on,
    output logic              m_drive_mode,
    output logic              m_stream_format
);
    logic          f_valid, f_ready, q_valid, q_ready;
    hcd_pkg::cmd_t f_cmd, q_cmd, b_cmd;

    hcd_front #(.NUM_JOINTS(NUM_JOINTS), .NUM_SERVOS(NUM_SERVOS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_byte(s_rx_byte),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    hcd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    hcd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_cmd),
        .out_valid(m_valid), .out_ready(m_ready), .out_cmd(b_cmd)
    );

    assign m_kind          = b_cmd.kind;
    assign m_elem_index    = b_cmd.elem_index;
    assign m_value         = b_cmd.word;
    assign m_ack_status    = b_cmd.ack_status;
    assign m_last          = b_cmd.last;
    assign m_control_on    = b_cmd.control_on;
    assign m_drive_mode    = b_cmd.drive_mode;
    assign m_stream_format = b_cmd.stream_format;

    a_ack_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ack_status |-> m_kind == hcd_pkg::KIND_MODE_ACK)
        else $error("ack status set on a result that is not a mode acknowledgement");
    a_motor_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last && m_kind == hcd_pkg::KIND_MOTOR |-> m_drive_mode)
        else $error("motor frame completed without direct mode");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic [3:0]  kind;
        logic [5:0]  elem_index;
        logic [31:0] value;
        logic        ack_status;
        logic        last;
        logic        control_on;
        logic        drive_mode;
        logic        stream_format;
    } host_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_kind;
    logic [5:0]  m_elem_index;
    logic [31:0] m_value;
    logic        m_ack_status;
    logic        m_last;
    logic        m_control_on;
    logic        m_drive_mode;
    logic        m_stream_format;

    localparam int NJ = 16;
    localparam int NS = 16;

    host_result_t expected_results[$];
    int   mismatch_count = 0;
    int   burst_left = 0;
    int   hold_off_cycles = 0;

    // Shadow state of the deframer.
    logic            sh_collecting;
    hcd_pkg::pend_t  sh_pending;
    int              sh_bytes;
    int              sh_elems;
    logic [31:0]     sh_word;
    logic            sh_enable;
    logic            sh_mode;
    logic            sh_stream;

    host_command_deframer #(.NUM_JOINTS(NJ), .NUM_SERVOS(NS)) i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [31:0] float_to_int32(logic [31:0] bits);
        logic [7:0]  ex;
        logic [31:0] mag;
        logic [33:0] mant;
        int          sh;
        ex = bits[30:23];
        if (ex == 8'hFF || ex < 8'd126) return 32'd0;
        if (ex >= 8'd158) return bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mant = {10'd0, 1'b1, bits[22:0]};
        if (ex >= 8'd150) begin
            mag = 32'(mant << (ex - 150));
        end else begin
            sh = 150 - ex;
            mag = 32'((mant + (34'd1 << (sh - 1))) >> sh);
        end
        return bits[31] ? -mag : mag;
    endfunction

    task automatic push_result(logic [3:0] k, int idx, logic [31:0] v, logic st, logic lst);
        host_result_t r;
        r.kind = k;
        r.elem_index = 6'(idx);
        r.value = v;
        r.ack_status = st;
        r.last = lst;
        r.control_on = sh_enable;
        r.drive_mode = sh_mode;
        r.stream_format = sh_stream;
        expected_results.push_back(r);
    endtask

    task automatic predict_byte(logic [7:0] b);
        int          idx;
        logic        lst;
        logic [31:0] v;
        idx = sh_elems;
        if (sh_collecting) begin
            if (sh_pending == hcd_pkg::PEND_STREAM) begin
                if (b <= 8'd1) sh_stream = b[0];
                sh_collecting = 1'b0;
                push_result(hcd_pkg::KIND_MODE_ACK, 0, {31'd0, sh_stream}, b > 8'd1, 1'b0);
            end else if (sh_pending == hcd_pkg::PEND_MOTOR) begin
                sh_word = {16'd0, sh_word[7:0], b};
                sh_bytes++;
                if (sh_bytes == 2) begin
                    v = {{16{sh_word[15]}}, sh_word[15:0]};
                    lst = (idx + 1 >= NS);
                    if (lst) begin
                        sh_mode = 1'b1;
                        sh_collecting = 1'b0;
                    end
                    sh_elems = idx + 1;
                    sh_bytes = 0;
                    sh_word = '0;
                    push_result(hcd_pkg::KIND_MOTOR, idx, v, 1'b0, lst);
                end
            end else begin
                sh_word[8*sh_bytes +: 8] = b;
                sh_bytes++;
                if (sh_bytes == 4) begin
                    lst = (idx + 1 >= NJ);
                    if (lst) begin
                        if (sh_pending == hcd_pkg::PEND_ANGLE) sh_mode = 1'b0;
                        sh_collecting = 1'b0;
                    end
                    sh_elems = idx + 1;
                    sh_bytes = 0;
                    if (sh_pending == hcd_pkg::PEND_ANGLE)
                        push_result(hcd_pkg::KIND_ANGLE, idx, sh_word, 1'b0, lst);
                    else
                        push_result(hcd_pkg::KIND_CALIB, idx, float_to_int32(sh_word), 1'b0,
                                    lst);
                    sh_word = '0;
                end
            end
        end else begin
            case (b)
                hcd_pkg::LEGACY_CAL, hcd_pkg::OP_CALIBRATE:
                    push_result(hcd_pkg::KIND_CALIBRATE, 0, 0, 0, 0);
                hcd_pkg::LEGACY_CLEAR: push_result(hcd_pkg::KIND_CLEAR, 0, 0, 0, 0);
                hcd_pkg::OP_START: begin
                    sh_enable = 1'b1;
                    push_result(hcd_pkg::KIND_START, 0, 0, 0, 0);
                end
                hcd_pkg::OP_STOP: begin
                    sh_enable = 1'b0;
                    push_result(hcd_pkg::KIND_STOP, 0, 0, 0, 0);
                end
                hcd_pkg::OP_RESET: begin
                    sh_enable = 1'b0;
                    sh_mode = 1'b0;
                    push_result(hcd_pkg::KIND_RESET, 0, 0, 0, 0);
                end
                hcd_pkg::OP_ANGLE, hcd_pkg::OP_CALIB_DATA, hcd_pkg::OP_MOTOR,
                hcd_pkg::OP_STREAM_MODE: begin
                    sh_collecting = 1'b1;
                    sh_pending = (b == hcd_pkg::OP_ANGLE) ? hcd_pkg::PEND_ANGLE :
                                 (b == hcd_pkg::OP_CALIB_DATA) ? hcd_pkg::PEND_CALIB :
                                 (b == hcd_pkg::OP_MOTOR) ? hcd_pkg::PEND_MOTOR :
                                                            hcd_pkg::PEND_STREAM;
                    sh_bytes = 0;
                    sh_elems = 0;
                    sh_word = '0;
                end
                default: ;
            endcase
        end
    endtask

    // Sends one byte, with gaps between random bursts unless told otherwise.
    task automatic send_byte(logic [7:0] b, bit no_gaps = 1'b0);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(b);
    endtask

    task automatic send_word_le(logic [31:0] w);
        for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
    endtask

    task automatic wait_drained();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_float();
        case ($urandom_range(0, 5))
            0: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom)};
            1: return {$urandom_range(0, 1) == 1, 8'($urandom_range(158, 254)), 23'($urandom)};
            2: return {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 126)), 23'($urandom)};
            3: return {$urandom_range(0, 1) == 1, 8'($urandom_range(126, 135)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_float_frame(logic [7:0] op);
        send_byte(op);
        for (int i = 0; i < NJ; i++) send_word_le(random_float());
    endtask

    task automatic send_motor_frame();
        send_byte(hcd_pkg::OP_MOTOR);
        for (int i = 0; i < 2 * NS; i++) send_byte(8'($urandom));
    endtask

    task automatic test_single_commands();
        logic [7:0] ops[9] = '{hcd_pkg::LEGACY_CAL, hcd_pkg::OP_CALIBRATE, hcd_pkg::LEGACY_CLEAR,
                               hcd_pkg::OP_START, hcd_pkg::OP_STOP, hcd_pkg::OP_START,
                               hcd_pkg::OP_RESET, 8'h00, 8'hFF};
        foreach (ops[i]) send_byte(ops[i]);
        send_byte(hcd_pkg::OP_STREAM_MODE);
        send_byte(8'd0);
        send_byte(hcd_pkg::OP_STREAM_MODE);
        send_byte(8'd2);
        send_byte(hcd_pkg::OP_STREAM_MODE);
        send_byte(8'hFF);
        send_byte(hcd_pkg::OP_STREAM_MODE);
        send_byte(8'd1);
        wait_drained();
    endtask

    task automatic test_frame_extremes();
        logic [31:0] w[8] = '{32'h3F00_0000, 32'hBF00_0000, 32'h7F80_0000, 32'h7FC0_0001,
                              32'h4F00_0000, 32'hCF00_0000, 32'h4EFF_FFFF, 32'h3EFF_FFFF};
        send_byte(hcd_pkg::OP_CALIB_DATA);
        for (int i = 0; i < NJ; i++) send_word_le(i < 8 ? w[i] : (i[0] ? 32'hFFFF_FFFF : 0));
        send_byte(hcd_pkg::OP_ANGLE);
        send_word_le(32'h0000_00CC);
        for (int i = 1; i < NJ; i++) send_word_le(i[0] ? 32'hCBCB_CBCB : 32'h0000_0000);
        send_byte(hcd_pkg::OP_MOTOR);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hFF);
        for (int i = 2; i < NS; i++) begin
            send_byte(8'hD0);
            send_byte(8'hCE);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin send_float_frame(hcd_pkg::OP_ANGLE); sent += 1 + 4 * NJ; end
                2, 3: begin send_float_frame(hcd_pkg::OP_CALIB_DATA); sent += 1 + 4 * NJ; end
                4, 5: begin send_motor_frame(); sent += 1 + 2 * NS; end
                6: begin
                    send_byte(hcd_pkg::OP_STREAM_MODE);
                    send_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1)));
                    sent += 2;
                end
                default: begin send_byte(8'($urandom)); sent++; end
            endcase
        end
        wait_drained();
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 200;
        for (int i = 0; i < 12; i++) send_byte(hcd_pkg::OP_START, 1'b1);
        wait_drained();
    endtask

    // Receiver: a repeating stall pattern, plus a long hold-off on request.
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_ready <= 1'b0;
            end else begin
                phase = (phase + 1) % 64;
                m_ready <= (phase < 24) ? 1'b1 : (phase < 40) ? phase[0] : ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        host_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result kind %0d", m_kind);
            end else begin
                e = expected_results.pop_front();
                if (m_kind !== e.kind || m_elem_index !== e.elem_index || m_value !== e.value ||
                    m_ack_status !== e.ack_status || m_last !== e.last ||
                    m_control_on !== e.control_on || m_drive_mode !== e.drive_mode ||
                    m_stream_format !== e.stream_format) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp %h %h %h %b%b%b%b%b got %h %h %h %b%b%b%b%b",
                                 e.kind, e.elem_index, e.value, e.ack_status, e.last,
                                 e.control_on, e.drive_mode, e.stream_format, m_kind,
                                 m_elem_index, m_value, m_ack_status, m_last, m_control_on,
                                 m_drive_mode, m_stream_format);
                end
            end
        end
    end

    initial begin
        sh_collecting = 1'b0;
        sh_pending = hcd_pkg::PEND_ANGLE;
        sh_bytes = 0;
        sh_elems = 0;
        sh_word = '0;
        sh_enable = 1'b0;
        sh_mode = 1'b0;
        sh_stream = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_commands();
        test_frame_extremes();
        test_back_pressure();
        test_random_traffic(300);
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
